// ===== hw/rtl/mau_pkg.sv =====
// Package for the modular arithmetic unit: widths, defaults, op codes, states.
package mau_pkg;

  localparam int unsigned DefaultWidth = 32;
  localparam int unsigned ModResetVal  = 17;
  localparam int unsigned CmdW         = 3;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_POW = 3'd4,
    CMD_INV = 3'd5,
    CMD_NEG = 3'd6,
    CMD_EQ  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_A_W,
    ST_RED_B,
    ST_RED_B_W,
    ST_DISPATCH,
    ST_INV_INIT,
    ST_INV_DIV,
    ST_INV_DIV_W,
    ST_INV_QMOD,
    ST_INV_QMOD_W,
    ST_INV_MUL,
    ST_INV_UPD,
    ST_INV_END,
    ST_MUL,
    ST_POW_INIT,
    ST_POW_STEP,
    ST_POW_ACC,
    ST_POW_SQR,
    ST_DONE
  } state_e;

endpackage

// ===== hw/rtl/mau_divider.sv =====
// Restoring divider: one quotient bit per cycle, quotient and remainder.
module mau_divider #(
  parameter int unsigned WIDTH = mau_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  mau_pkg::div_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] quot_q, quot_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  assign trial = {rem_q, quot_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mau_pkg::DIV_IDLE: if (start_i) state_d = mau_pkg::DIV_RUN;
      mau_pkg::DIV_RUN:  if (cnt_q == CntW'(1)) state_d = mau_pkg::DIV_DONE;
      mau_pkg::DIV_DONE: state_d = mau_pkg::DIV_IDLE;
      default:           state_d = mau_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    unique case (state_q)
      mau_pkg::DIV_IDLE: begin
        if (start_i) begin
          cnt_d  = CntW'(WIDTH);
          quot_d = dividend_i;
          rem_d  = '0;
          dvs_d  = divisor_i;
        end
      end
      mau_pkg::DIV_RUN: begin
        cnt_d = cnt_q - CntW'(1);
        if (!diff[WIDTH]) begin
          rem_d  = diff[WIDTH-1:0];
          quot_d = {quot_q[WIDTH-2:0], 1'b1};
        end else begin
          rem_d  = trial[WIDTH-1:0];
          quot_d = {quot_q[WIDTH-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mau_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = (state_q == mau_pkg::DIV_DONE);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/mau_modmul.sv =====
// Shift-and-add modular multiplier: one multiplier bit per cycle.
module mau_modmul #(
  parameter int unsigned WIDTH = mau_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] mod_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH:0]   s_acc;
  logic [WIDTH:0]   s_dbl;
  logic [WIDTH-1:0] acc_add;
  logic [WIDTH-1:0] y_dbl;

  assign s_acc   = {1'b0, acc_q} + {1'b0, y_q};
  assign s_dbl   = {1'b0, y_q} + {1'b0, y_q};
  assign acc_add = (s_acc >= {1'b0, mod_i}) ? WIDTH'(s_acc - {1'b0, mod_i}) : s_acc[WIDTH-1:0];
  assign y_dbl   = (s_dbl >= {1'b0, mod_i}) ? WIDTH'(s_dbl - {1'b0, mod_i}) : s_dbl[WIDTH-1:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        x_d    = x_i;
        y_d    = y_i;
        acc_d  = '0;
      end
    end else if (x_q == '0) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end else begin
      if (x_q[0]) acc_d = acc_add;
      y_d = y_dbl;
      x_d = x_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hw/rtl/modular_arithmetic_unit_core.sv =====
// Top level of the modular arithmetic unit: sequencer over a shared divider and multiplier.
//
//  channel | signals                                               | handshake
//  --------+-------------------------------------------------------+---------------------------
//  command | start, busy, cmd_i, operand_a/b_i, exponent_i          | start & !busy
//  result  | done_o, result_o, no_inverse_o, is_equal_o            | done_o, one cycle
//  config  | cfg_valid_i, cfg_ready_o, cfg_data_i                  | cfg_valid_i & cfg_ready_o
//
// An item takes two reductions by the modulus plus its operation: add/sub/neg/eq are
// computed without a unit, mul takes one multiply, div/inverse run Euclid rounds of two
// divisions and one multiply each (div then one more multiply), power up to 2*WIDTH
// multiplies after an inverse for a negative exponent.
// Reset sets the modulus to 17. Results cannot be stalled.
module modular_arithmetic_unit_core #(
  parameter int unsigned WIDTH = mau_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [mau_pkg::CmdW-1:0] cmd_i,
  input  logic [WIDTH-1:0] operand_a_i,
  input  logic [WIDTH-1:0] operand_b_i,
  input  logic signed [WIDTH-1:0] exponent_i,
  output logic             done_o,
  output logic [WIDTH-1:0] result_o,
  output logic             no_inverse_o,
  output logic             is_equal_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [WIDTH-1:0] cfg_data_i
);

  mau_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0] modulus_q;
  logic [WIDTH-1:0] m_eff;
  logic [mau_pkg::CmdW-1:0] cmd_q, cmd_d;
  logic [WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [WIDTH-1:0] e_q, e_d;
  logic             eneg_q, eneg_d;
  logic [WIDTH-1:0] ra_q, ra_d, rb_q, rb_d, ca_q, ca_d, cb_q, cb_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic             noinv_q, noinv_d, eq_q, eq_d;
  logic             done_q, done_d;

  logic             div_start;
  logic [WIDTH-1:0] div_n, div_dv, div_quot, div_rem;
  logic             div_done;
  logic             mul_start;
  logic [WIDTH-1:0] mul_x, mul_y, mul_p;
  logic             mul_done;

  logic [WIDTH:0]   sum_w;
  logic [WIDTH-1:0] sum_r;
  logic [WIDTH-1:0] neg_b, neg_a, neg_p;
  logic [WIDTH:0]   upd_sum;
  logic [WIDTH-1:0] one_m;

  assign m_eff = (modulus_q == '0) ? WIDTH'(1) : modulus_q;
  assign one_m = (m_eff == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign neg_b = (b_q == '0) ? '0 : m_eff - b_q;
  assign neg_a = (a_q == '0) ? '0 : m_eff - a_q;
  assign neg_p = (mul_p == '0) ? '0 : m_eff - mul_p;
  assign sum_w = {1'b0, a_q} + {1'b0, (cmd_q == mau_pkg::CMD_SUB) ? neg_b : b_q};
  assign sum_r = (sum_w >= {1'b0, m_eff}) ? WIDTH'(sum_w - {1'b0, m_eff}) : sum_w[WIDTH-1:0];
  assign upd_sum = {1'b0, ca_q} + {1'b0, neg_p};

  mau_divider #(.WIDTH(WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_dv),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  mau_modmul #(.WIDTH(WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .mod_i   (m_eff),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mau_pkg::ST_IDLE:      if (start) state_d = mau_pkg::ST_RED_A;
      mau_pkg::ST_RED_A:     state_d = mau_pkg::ST_RED_A_W;
      mau_pkg::ST_RED_A_W:   if (div_done) state_d = mau_pkg::ST_RED_B;
      mau_pkg::ST_RED_B:     state_d = mau_pkg::ST_RED_B_W;
      mau_pkg::ST_RED_B_W:   if (div_done) state_d = mau_pkg::ST_DISPATCH;
      mau_pkg::ST_DISPATCH: begin
        unique case (mau_pkg::cmd_e'(cmd_q))
          mau_pkg::CMD_MUL: state_d = mau_pkg::ST_MUL;
          mau_pkg::CMD_DIV: state_d = mau_pkg::ST_INV_INIT;
          mau_pkg::CMD_INV: state_d = mau_pkg::ST_INV_INIT;
          mau_pkg::CMD_POW: state_d = eneg_q ? mau_pkg::ST_INV_INIT : mau_pkg::ST_POW_INIT;
          default:          state_d = mau_pkg::ST_DONE;
        endcase
      end
      mau_pkg::ST_INV_INIT:   state_d = mau_pkg::ST_INV_DIV;
      mau_pkg::ST_INV_DIV:    state_d = (rb_q == '0) ? mau_pkg::ST_INV_END
                                                     : mau_pkg::ST_INV_DIV_W;
      mau_pkg::ST_INV_DIV_W:  if (div_done) state_d = mau_pkg::ST_INV_QMOD;
      mau_pkg::ST_INV_QMOD:   state_d = mau_pkg::ST_INV_QMOD_W;
      mau_pkg::ST_INV_QMOD_W: if (div_done) state_d = mau_pkg::ST_INV_MUL;
      mau_pkg::ST_INV_MUL:    if (mul_done) state_d = mau_pkg::ST_INV_UPD;
      mau_pkg::ST_INV_UPD:    state_d = mau_pkg::ST_INV_DIV;
      mau_pkg::ST_INV_END: begin
        if (ra_q != WIDTH'(1) || a_q == '0) state_d = mau_pkg::ST_DONE;
        else if (cmd_q == mau_pkg::CMD_DIV) state_d = mau_pkg::ST_MUL;
        else if (cmd_q == mau_pkg::CMD_POW) state_d = mau_pkg::ST_POW_INIT;
        else state_d = mau_pkg::ST_DONE;
      end
      mau_pkg::ST_MUL:      if (mul_done) state_d = mau_pkg::ST_DONE;
      mau_pkg::ST_POW_INIT: state_d = mau_pkg::ST_POW_STEP;
      mau_pkg::ST_POW_STEP: begin
        if (e_q == '0) state_d = mau_pkg::ST_DONE;
        else if (e_q[0]) state_d = mau_pkg::ST_POW_ACC;
        else state_d = mau_pkg::ST_POW_SQR;
      end
      mau_pkg::ST_POW_ACC: if (mul_done) state_d = mau_pkg::ST_POW_SQR;
      mau_pkg::ST_POW_SQR: if (mul_done) state_d = mau_pkg::ST_POW_STEP;
      mau_pkg::ST_DONE:    state_d = mau_pkg::ST_IDLE;
      default:             state_d = mau_pkg::ST_IDLE;
    endcase
  end

  // In DIV the inverse runs on b: swap b into a first, keep a in acc.
  always_comb begin
    cmd_d = cmd_q; a_d = a_q; b_d = b_q; e_d = e_q; eneg_d = eneg_q;
    ra_d = ra_q; rb_d = rb_q; ca_d = ca_q; cb_d = cb_q;
    quo_d = quo_q; rem_d = rem_q; acc_d = acc_q;
    res_d = res_q; noinv_d = noinv_q; eq_d = eq_q; done_d = 1'b0;
    div_start = 1'b0; div_n = a_q; div_dv = m_eff;
    mul_start = 1'b0; mul_x = a_q; mul_y = b_q;
    unique case (state_q)
      mau_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          a_d     = operand_a_i;
          b_d     = operand_b_i;
          eneg_d  = exponent_i[WIDTH-1];
          e_d     = exponent_i[WIDTH-1] ? WIDTH'(-exponent_i) : exponent_i;
          res_d   = '0;
          noinv_d = 1'b0;
          eq_d    = 1'b0;
        end
      end
      mau_pkg::ST_RED_A: begin
        div_start = 1'b1; div_n = a_q;
      end
      mau_pkg::ST_RED_A_W: if (div_done) a_d = div_rem;
      mau_pkg::ST_RED_B: begin
        div_start = 1'b1; div_n = b_q;
      end
      mau_pkg::ST_RED_B_W: if (div_done) b_d = div_rem;
      mau_pkg::ST_DISPATCH: begin
        unique case (mau_pkg::cmd_e'(cmd_q))
          mau_pkg::CMD_ADD, mau_pkg::CMD_SUB: res_d = sum_r;
          mau_pkg::CMD_NEG: res_d = neg_a;
          mau_pkg::CMD_EQ:  eq_d = (a_q == b_q);
          mau_pkg::CMD_MUL: begin
            mul_start = 1'b1;
          end
          mau_pkg::CMD_DIV: begin
            acc_d = a_q;
            a_d   = b_q;
          end
          default: ;
        endcase
      end
      mau_pkg::ST_INV_INIT: begin
        ra_d = m_eff; rb_d = a_q; ca_d = '0; cb_d = one_m;
      end
      mau_pkg::ST_INV_DIV: begin
        if (rb_q != '0) begin
          div_start = 1'b1; div_n = ra_q; div_dv = rb_q;
        end
      end
      mau_pkg::ST_INV_DIV_W: if (div_done) begin
        quo_d = div_quot; rem_d = div_rem;
      end
      mau_pkg::ST_INV_QMOD: begin
        div_start = 1'b1; div_n = quo_q;
      end
      mau_pkg::ST_INV_QMOD_W: if (div_done) begin
        quo_d = div_rem;
        mul_start = 1'b1; mul_x = cb_q; mul_y = div_rem;
      end
      mau_pkg::ST_INV_MUL: ;
      mau_pkg::ST_INV_UPD: begin
        ra_d = rb_q;
        rb_d = rem_q;
        ca_d = cb_q;
        cb_d = (upd_sum >= {1'b0, m_eff}) ? WIDTH'(upd_sum - {1'b0, m_eff})
                                          : upd_sum[WIDTH-1:0];
      end
      mau_pkg::ST_INV_END: begin
        if (ra_q != WIDTH'(1) || a_q == '0) begin
          noinv_d = 1'b1;
          res_d   = '0;
        end else if (cmd_q == mau_pkg::CMD_DIV) begin
          mul_start = 1'b1; mul_x = acc_q; mul_y = ca_q;
        end else if (cmd_q == mau_pkg::CMD_POW) begin
          a_d = ca_q;
        end else begin
          res_d = ca_q;
        end
      end
      mau_pkg::ST_MUL: if (mul_done) res_d = mul_p;
      mau_pkg::ST_POW_INIT: acc_d = one_m;
      mau_pkg::ST_POW_STEP: begin
        if (e_q == '0) res_d = acc_q;
        else if (e_q[0]) begin
          mul_start = 1'b1; mul_x = acc_q; mul_y = a_q;
        end else begin
          mul_start = 1'b1; mul_x = a_q; mul_y = a_q;
        end
      end
      mau_pkg::ST_POW_ACC: if (mul_done) begin
        acc_d = mul_p;
        mul_start = 1'b1; mul_x = a_q; mul_y = a_q;
      end
      mau_pkg::ST_POW_SQR: if (mul_done) begin
        a_d = mul_p;
        e_d = e_q >> 1;
      end
      mau_pkg::ST_DONE: done_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mau_pkg::ST_IDLE;
      modulus_q <= WIDTH'(mau_pkg::ModResetVal);
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) modulus_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; a_q <= a_d; b_q <= b_d; e_q <= e_d; eneg_q <= eneg_d;
    ra_q <= ra_d; rb_q <= rb_d; ca_q <= ca_d; cb_q <= cb_d;
    quo_q <= quo_d; rem_q <= rem_d; acc_q <= acc_d;
    res_q <= res_d; noinv_q <= noinv_d; eq_q <= eq_d;
  end

  assign busy         = (state_q != mau_pkg::ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign done_o       = done_q;
  assign result_o     = res_q;
  assign no_inverse_o = noinv_q;
  assign is_equal_o   = eq_q;

endmodule
